// ----- design/ps2mt_pkg.sv -----
// Shared types, constants and arithmetic helpers for the PS/2 mouse packet tracker.
// No dependencies; imported by ps2mt_pos_update, ps2_mouse_packet_tracker and the testbench.
package ps2mt_pkg;

    localparam int COORD_W = 10;
    localparam int BYTE_W  = 8;
    // wide enough for coord + delta, with sign: -511 .. 1534
    localparam int SUM_W   = 12;

    localparam logic [COORD_W-1:0] LIMIT_RESET = 10'd120;
    localparam logic [SUM_W-1:0]   OVF_EXTRA   = 12'd255;

    // packet phase codes
    localparam logic [1:0] PHASE_HEADER = 2'd0;
    localparam logic [1:0] PHASE_X      = 2'd1;
    localparam logic [1:0] PHASE_Y      = 2'd2;

    // configuration register indexes
    localparam logic CFG_X_LIMIT = 1'b0;
    localparam logic CFG_Y_LIMIT = 1'b1;

    // header bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;
    localparam int HDR_X_OVF  = 6;
    localparam int HDR_Y_OVF  = 7;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } coord_t;

    typedef struct packed {
        logic left;
        logic middle;
        logic right;
    } buttons_t;

    // 9-bit two's complement delta, pushed 255 further from zero on overflow
    function automatic logic signed [SUM_W-1:0] signed_delta(
        input logic [BYTE_W-1:0] low,
        input logic              neg,
        input logic              ovf
    );
        logic signed [SUM_W-1:0] d;
        d = {{(SUM_W-BYTE_W){neg}}, low};
        if (ovf)
        begin
            if (neg)
                d = d - OVF_EXTRA;
            else
                d = d + OVF_EXTRA;
        end
        return d;
    endfunction

    // clamp negatives to zero, hold previous value above the limit
    function automatic logic [COORD_W-1:0] bound_coord(
        input logic signed [SUM_W-1:0] v,
        input logic [COORD_W-1:0]      prev,
        input logic [COORD_W-1:0]      limit
    );
        logic [COORD_W-1:0] r;
        if (v[SUM_W-1])
            r = '0;
        else if (v > $signed({{(SUM_W-COORD_W){1'b0}}, limit}))
            r = prev;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

// ----- design/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker: byte sequencing, limits and result register.
// Depends on ps2mt_pkg and ps2mt_pos_update.
//
//   channel   signals                                   direction
//   in        in_valid, in_ready, rx_byte               byte from the mouse
//   out       out_valid, out_ready, pos_x, pos_y,       one transaction per packet
//             left_button, middle_button, right_button
//   cfg       cfg_we, cfg_index, cfg_data               limit writes, no handshake
//
// One byte is taken per cycle; the third byte of a packet yields a result in the
// next cycle from the output register. rst_n clears the phase and position and
// returns both limits to 120, asynchronously. While a result waits on out_ready,
// bytes that do not finish a packet are still taken; only a packet-ending byte stalls.
module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] pos_x,
    output logic [COORD_W-1:0] pos_y,
    output logic               left_button,
    output logic               middle_button,
    output logic               right_button,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [COORD_W-1:0] cfg_data
);

    logic [1:0]        phase_reg, phase_next;
    logic              skip_first_reg, skip_first_next;
    logic [BYTE_W-1:0] header_reg, header_next;
    logic [BYTE_W-1:0] x_byte_reg, x_byte_next;
    coord_t            cur_reg, cur_next;
    coord_t            limit_reg;
    buttons_t          btn_reg, btn_next;
    logic              out_valid_reg, out_valid_next;

    coord_t            upd_pos;
    logic              accept;
    logic              finishing;

    ps2mt_pos_update u_pos_update (
        .header   (header_reg),
        .x_byte   (x_byte_reg),
        .y_byte   (rx_byte),
        .cur      (cur_reg),
        .limit    (limit_reg),
        .next_pos (upd_pos)
    );

    assign finishing = !skip_first_reg && (phase_reg == PHASE_Y);
    assign in_ready  = !(finishing && out_valid_reg && !out_ready);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        skip_first_next = skip_first_reg;
        header_next     = header_reg;
        x_byte_next     = x_byte_reg;
        cur_next        = cur_reg;
        btn_next        = btn_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (accept)
        begin
            if (skip_first_reg)
            begin
                // drop the first byte after reset
                skip_first_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PHASE_X:
                    begin
                        x_byte_next = rx_byte;
                        phase_next  = PHASE_Y;
                    end
                    PHASE_Y:
                    begin
                        phase_next      = PHASE_HEADER;
                        cur_next        = upd_pos;
                        btn_next.left   = header_reg[HDR_LEFT];
                        btn_next.middle = header_reg[HDR_MIDDLE];
                        btn_next.right  = header_reg[HDR_RIGHT];
                        out_valid_next  = 1'b1;
                    end
                    default:
                    begin
                        // resync: a packet opens only on a byte with the sync bit
                        if (rx_byte[HDR_SYNC])
                        begin
                            header_next = rx_byte;
                            phase_next  = PHASE_X;
                        end
                        else
                        begin
                            phase_next = PHASE_HEADER;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_HEADER;
            skip_first_reg <= 1'b1;
            header_reg     <= '0;
            x_byte_reg     <= '0;
            cur_reg        <= '0;
            btn_reg        <= '0;
            out_valid_reg  <= 1'b0;
            limit_reg.x    <= LIMIT_RESET;
            limit_reg.y    <= LIMIT_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            skip_first_reg <= skip_first_next;
            header_reg     <= header_next;
            x_byte_reg     <= x_byte_next;
            cur_reg        <= cur_next;
            btn_reg        <= btn_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_X_LIMIT: limit_reg.x <= cfg_data;
                    CFG_Y_LIMIT: limit_reg.y <= cfg_data;
                    default:     limit_reg   <= limit_reg;
                endcase
            end
        end
    end

    // position only moves together with a new result, so it drives the output directly
    assign out_valid     = out_valid_reg;
    assign pos_x         = cur_reg.x;
    assign pos_y         = cur_reg.y;
    assign left_button   = btn_reg.left;
    assign middle_button = btn_reg.middle;
    assign right_button  = btn_reg.right;

    // a packet-ending byte always produces a result
    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && finishing) |=> out_valid_reg)
        else $error("finished packet gave no result");

    // the dropped first byte leaves the packet phase alone
    a_skip_first: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && skip_first_reg) |=> (!skip_first_reg && $stable(phase_reg)))
        else $error("first byte after reset not dropped cleanly");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && finishing))
        else $error("input stalled without a pending result");

endmodule

// ----- design/ps2mt_pos_update.sv -----
// Position update for one finished packet: forms X/Y deltas and bounds the new cursor.
// Depends on ps2mt_pkg.
module ps2mt_pos_update
    import ps2mt_pkg::*;
(
    input  logic [BYTE_W-1:0]  header,
    input  logic [BYTE_W-1:0]  x_byte,
    input  logic [BYTE_W-1:0]  y_byte,
    input  coord_t             cur,
    input  coord_t             limit,
    output coord_t             next_pos
);

    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic signed [SUM_W-1:0] nx;
    logic signed [SUM_W-1:0] ny;

    always_comb
    begin
        dx = signed_delta(x_byte, header[HDR_X_SIGN], header[HDR_X_OVF]);
        dy = signed_delta(y_byte, header[HDR_Y_SIGN], header[HDR_Y_OVF]);
        nx = $signed({{(SUM_W-COORD_W){1'b0}}, cur.x}) + dx;
        // screen Y grows downward
        ny = $signed({{(SUM_W-COORD_W){1'b0}}, cur.y}) - dy;
        next_pos.x = bound_coord(nx, cur.x, limit.x);
        next_pos.y = bound_coord(ny, cur.y, limit.y);
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for ps2_mouse_packet_tracker: directed byte table, then random packets and stray bytes.
// Depends on ps2mt_pkg and the tracker RTL; the table gives directed results, its own cursor tracker the rest.
module testbench
    import ps2mt_pkg::*;
();

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               left;
        logic               middle;
        logic               right;
    } packet_result_t;

    typedef struct {
        logic [BYTE_W-1:0] b;
        bit                chk;
        packet_result_t    res;
    } byte_row_t;

    localparam int DIR_ROWS   = 26;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [BYTE_W-1:0]  rx_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               left_button;
    logic               middle_button;
    logic               right_button;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_X_LIMIT;
    logic [COORD_W-1:0] cfg_data = '0;

    // tracker state mirrored from the block
    logic [1:0]         trk_phase;
    bit                 trk_skip;
    logic [BYTE_W-1:0]  trk_header;
    logic [BYTE_W-1:0]  trk_xbyte;
    logic [COORD_W-1:0] trk_x;
    logic [COORD_W-1:0] trk_y;
    logic [COORD_W-1:0] lim_x;
    logic [COORD_W-1:0] lim_y;

    packet_result_t     pending_packets[$];
    bit                 held_chk = 1'b0;
    packet_result_t     held_res = '0;
    bit                 calm = 1'b0;
    int                 err_count = 0;
    int                 ready_hold = 0;
    byte_row_t          dir_rows [0:DIR_ROWS-1];

    ps2_mouse_packet_tracker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .left_button   (left_button),
        .middle_button (middle_button),
        .right_button  (right_button),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int movement(input logic [BYTE_W-1:0] low, input logic neg,
                                    input logic ovf);
        int d;
        d = int'(low);
        if (neg)
        begin
            d = d - 256;
            if (ovf)
                d = d - 255;
        end
        else if (ovf)
            d = d + 255;
        return d;
    endfunction

    function automatic logic [COORD_W-1:0] clip_coord(input int v,
                                                      input logic [COORD_W-1:0] prev,
                                                      input logic [COORD_W-1:0] limit);
        if (v < 0)
            return '0;
        else if (v > int'(limit))
            return prev;
        else
            return COORD_W'(v);
    endfunction

    task automatic track_byte(input logic [BYTE_W-1:0] b, output bit has,
                              output packet_result_t r);
        int nx;
        int ny;
        has = 1'b0;
        r = '0;
        if (trk_skip)
            trk_skip = 1'b0;
        else if (trk_phase == PHASE_X)
        begin
            trk_xbyte = b;
            trk_phase = PHASE_Y;
        end
        else if (trk_phase != PHASE_Y)
        begin
            if (b[HDR_SYNC])
            begin
                trk_header = b;
                trk_phase = PHASE_X;
            end
            else
                trk_phase = PHASE_HEADER;
        end
        else
        begin
            trk_phase = PHASE_HEADER;
            nx = int'(trk_x) + movement(trk_xbyte, trk_header[HDR_X_SIGN],
                                        trk_header[HDR_X_OVF]);
            ny = int'(trk_y) - movement(b, trk_header[HDR_Y_SIGN], trk_header[HDR_Y_OVF]);
            trk_x = clip_coord(nx, trk_x, lim_x);
            trk_y = clip_coord(ny, trk_y, lim_y);
            has = 1'b1;
            r.x = trk_x;
            r.y = trk_y;
            r.left = trk_header[HDR_LEFT];
            r.middle = trk_header[HDR_MIDDLE];
            r.right = trk_header[HDR_RIGHT];
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // Track inputs, config writes and results on the same edge the block sees them.
    always @(posedge clk)
    begin
        bit             has;
        packet_result_t r;
        packet_result_t e;
        if (!rst_n)
        begin
            trk_phase = PHASE_HEADER;
            trk_skip = 1'b1;
            trk_header = '0;
            trk_xbyte = '0;
            trk_x = '0;
            trk_y = '0;
            lim_x = LIMIT_RESET;
            lim_y = LIMIT_RESET;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_packets.size() == 0)
                begin
                    $error("unexpected transaction: pos_x=%0d pos_y=%0d", pos_x, pos_y);
                    err_count++;
                end
                else
                begin
                    e = pending_packets.pop_front();
                    check_field("pos_x", e.x, pos_x);
                    check_field("pos_y", e.y, pos_y);
                    check_field("left_button", e.left, left_button);
                    check_field("middle_button", e.middle, middle_button);
                    check_field("right_button", e.right, right_button);
                end
            end
            if (in_valid && in_ready)
            begin
                track_byte(rx_byte, has, r);
                if (held_chk || has)
                    pending_packets.push_back(held_chk ? held_res : r);
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_X_LIMIT)
                    lim_x = cfg_data;
                else if (cfg_index == CFG_Y_LIMIT)
                    lim_y = cfg_data;
            end
        end
    end

    // Stall the result side at random.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_hold = pick_gap();
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit chk,
                             input packet_result_t res);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        held_chk = chk;
        held_res = res;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_delta(input logic neg);
        if ($urandom_range(0, 1) == 1)
            return BYTE_W'($urandom_range(0, 255));
        else if (neg)
            return BYTE_W'(256 - $urandom_range(1, 16));
        else
            return BYTE_W'($urandom_range(0, 15));
    endfunction

    task automatic send_random_packet();
        logic [BYTE_W-1:0] h;
        h = BYTE_W'($urandom_range(0, 255));
        h[HDR_SYNC] = 1'b1;
        h[HDR_X_OVF] = ($urandom_range(0, 7) == 0);
        h[HDR_Y_OVF] = ($urandom_range(0, 7) == 0);
        send_byte(h, 1'b0, '0);
        send_byte(pick_delta(h[HDR_X_SIGN]), 1'b0, '0);
        send_byte(pick_delta(h[HDR_Y_SIGN]), 1'b0, '0);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        held_chk = 1'b0;
        while (pending_packets.size() != 0)
            @(posedge clk);
        // let a partial packet or a result register settle
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limits(input logic [COORD_W-1:0] xl, input logic [COORD_W-1:0] yl);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_X_LIMIT;
        cfg_data <= xl;
        @(negedge clk);
        cfg_index <= CFG_Y_LIMIT;
        cfg_data <= yl;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [COORD_W-1:0] set_x [0:PHASES-1];
        logic [COORD_W-1:0] set_y [0:PHASES-1];
        int                 sent;
        int                 r;

        // byte, typed check, expected {x, y, left, middle, right}
        dir_rows = '{
            '{8'h00, 1'b0, '0},                          // dropped after reset
            '{8'h00, 1'b0, '0},                          // no sync bit, ignored
            '{8'h09, 1'b0, '0},
            '{8'h10, 1'b0, '0},
            '{8'h20, 1'b1, {10'd16, 10'd0, 1'b1, 1'b0, 1'b0}},    // Y clamps to zero
            '{8'h2E, 1'b0, '0},
            '{8'h05, 1'b0, '0},
            '{8'hC0, 1'b0, '0},
            '{8'h38, 1'b0, '0},                          // sign bits set, zero low bytes: -256 on both axes
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b1, {10'd0, 10'd64, 1'b0, 1'b0, 1'b0}},
            '{8'h48, 1'b0, '0},                          // X overflow, past the limit
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b1, {10'd0, 10'd64, 1'b0, 1'b0, 1'b0}},
            '{8'hB8, 1'b0, '0},                          // Y overflow, negative
            '{8'h01, 1'b0, '0},
            '{8'h00, 1'b1, {10'd0, 10'd64, 1'b0, 1'b0, 1'b0}},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b1, {10'd0, 10'd64, 1'b1, 1'b1, 1'b1}},
            '{8'h08, 1'b0, '0},                          // land exactly on the limit
            '{8'h78, 1'b0, '0},
            '{8'h40, 1'b1, {10'd120, 10'd0, 1'b0, 1'b0, 1'b0}},
            '{8'h08, 1'b0, '0},                          // one past the limit, hold
            '{8'h01, 1'b0, '0},
            '{8'h00, 1'b1, {10'd120, 10'd0, 1'b0, 1'b0, 1'b0}}
        };
        set_x = '{10'd1023, 10'd7, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd120};
        set_y = '{10'd1023, 10'd7, 10'd0, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd120};
        set_x[5] = COORD_W'($urandom_range(0, 1023));
        set_y[5] = COORD_W'($urandom_range(0, 1023));
        set_x[6] = COORD_W'($urandom_range(0, 1023));
        set_y[6] = COORD_W'($urandom_range(0, 1023));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(dir_rows[i].b, dir_rows[i].chk, dir_rows[i].res);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_limits(set_x[p], set_y[p]);
            calm = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_LEN)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    send_random_packet();
                    sent += 3;
                end
                else if (r < 95)
                begin
                    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                    sent += 1;
                end
                else
                begin
                    // broken packet: header and one byte only
                    send_byte(BYTE_W'($urandom_range(0, 255)) | 8'h08, 1'b0, '0);
                    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                    sent += 2;
                end
            end
        end

        calm = 1'b0;
        wait_idle();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule
